FILE: rtl/core/dcsp_pkg.sv
package dcsp_pkg;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 328;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] LEVEL_SOCKET = 16'd1;
  localparam logic [7:0]  TYPE_HEADER  = 8'd98;
  localparam logic [7:0]  TYPE_OFFSET  = 8'd99;
  localparam logic [7:0]  TYPE_DMABUF  = 8'h42;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BOUNCE_BASE = 2'd0,
    REG_BOUNCE_SIZE = 2'd1,
    REG_DMABUF_BASE = 2'd2,
    REG_DMABUF_SIZE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_NO_RECORDS = 3'd2,
    ST_NO_DATA    = 3'd3,
    ST_NO_BOUNCE  = 3'd4
  } status_t;

  typedef enum logic {
    KIND_SCATTER = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        dev_frag;
    logic [31:0] src_off;
    logic [63:0] src_address;
    logic [31:0] dst_off;
    logic [31:0] length;
    logic [31:0] token;
    status_t     status;
    logic [63:0] bytes_total;
    logic [63:0] bytes_linear;
    logic        last;
  } res_t;

endpackage

FILE: rtl/core/devmem_cmsg_scatter_parser_core.sv
// Channel | Ports                         | Transaction
// --------+-------------------------------+------------------------------------
// in      | in_tvalid/tready/tdata/tuser/ | one receive control record;
//         | in_tlast                      | tuser = end_only, tlast = last_record
// out     | out_tvalid/tready/tdata/      | scatter entry or message status;
//         | out_tuser/out_tlast           | tuser = kind, tlast = last
// cfg     | cfg_wr_en/cfg_addr/cfg_wdata  | register write, no read-back
//
// One record a cycle while each record yields at most one result and the out side
// does not stall. A record that yields an entry plus a status waits for an empty
// two-entry result queue. Records are registered in the input stage, results in the queue.
// rst_n is synchronous and clears the input stage, queue and message state.
// in_tready depends only on registers; a stalled out side fills the queue and
// then holds the input stage.
module devmem_cmsg_scatter_parser_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // record_level[15:0], record_type[23:16], fragment offset[55:24],
  // fragment size[87:56], fragment token[119:88]
  input  logic [dcsp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // end_only
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // dev_frag[0], src_off[32:1], src_address[96:33], dst_off[128:97],
  // length[160:129], token[192:161], status[195:193], bytes_total[259:196],
  // bytes_linear[323:260], zero pad[327:324]
  output logic [dcsp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // kind
  output logic                               out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_wr_en,
  input  logic [dcsp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dcsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import dcsp_pkg::*;

  logic [63:0] bounce_base_r, dmabuf_base_r;
  logic [31:0] bounce_size_r, dmabuf_size_r;

  logic                  in_valid_r;
  logic [IN_TDATA_W-1:0] in_data_r;
  logic                  in_end_r, in_last_r;

  logic [63:0] host_offset_r, host_offset_nxt;
  logic [63:0] running_dst_r, running_dst_nxt;
  logic        saw_record_r, saw_record_nxt;
  logic        aborted_r, aborted_nxt;
  logic        saw_linear_r, saw_linear_nxt;

  res_t       q_r [QUEUE_DEPTH];
  res_t       q_nxt [QUEUE_DEPTH];
  logic [1:0] count_r, count_nxt;

  logic [15:0] level;
  logic [7:0]  rtype;
  logic [31:0] foff, fsize, ftok;
  logic        is_rec, is_hdr, lin_bad, dev_bad, err, entry;
  logic [31:0] lin_sum, dev_sum;
  logic [63:0] add_dst, add_host, dst_sum, host_sum;
  logic [63:0] src_base, src_off64, src_addr;
  logic [1:0]  n_res, free_slots, base;
  logic        fire, pop, clr;
  status_t     st;
  res_t        err_res, ent_res, st_res, r0;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounce_base_r <= '0;
      bounce_size_r <= '0;
      dmabuf_base_r <= '0;
      dmabuf_size_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_BOUNCE_BASE: bounce_base_r <= cfg_wdata;
        REG_BOUNCE_SIZE: bounce_size_r <= cfg_wdata[31:0];
        REG_DMABUF_BASE: dmabuf_base_r <= cfg_wdata;
        REG_DMABUF_SIZE: dmabuf_size_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // input stage
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_end_r  <= in_tuser;
      in_last_r <= in_tlast;
    end
  end

  // record decode and checks
  always_comb begin
    level = in_data_r[15:0];
    rtype = in_data_r[23:16];
    foff  = in_data_r[55:24];
    fsize = in_data_r[87:56];
    ftok  = in_data_r[119:88];

    is_rec = !in_end_r && (level == LEVEL_SOCKET) &&
             (rtype == TYPE_HEADER || rtype == TYPE_OFFSET || rtype == TYPE_DMABUF);
    is_hdr = (rtype == TYPE_HEADER);

    lin_sum = host_offset_r[31:0] + fsize;
    dev_sum = foff + fsize;
    lin_bad = (bounce_base_r == '0) || (bounce_size_r == '0) || (lin_sum > bounce_size_r);
    dev_bad = (dmabuf_base_r != '0) && (dmabuf_size_r != '0) && (dev_sum > dmabuf_size_r);

    err   = is_rec && (is_hdr ? ((fsize != '0) && lin_bad) : dev_bad);
    // an empty linear fragment counts as seen but is skipped
    entry = is_rec && !err && !(is_hdr && (fsize == '0));

    add_dst  = entry ? {32'd0, fsize} : 64'd0;
    add_host = (entry && is_hdr) ? {32'd0, fsize} : 64'd0;
    dst_sum  = running_dst_r + add_dst;
    host_sum = host_offset_r + add_host;

    src_base  = is_hdr ? bounce_base_r : dmabuf_base_r;
    src_off64 = is_hdr ? host_offset_r : {32'd0, foff};
    src_addr  = src_base + src_off64;

    if (!(saw_record_r || is_rec)) begin
      st = ST_NO_RECORDS;
    end else if (dst_sum == '0) begin
      st = ST_NO_DATA;
    end else if ((saw_linear_r || (entry && is_hdr)) && (bounce_base_r == '0)) begin
      st = ST_NO_BOUNCE;
    end else begin
      st = ST_OK;
    end
  end

  // result assembly
  always_comb begin
    err_res              = '0;
    err_res.kind         = KIND_STATUS;
    err_res.status       = ST_INVALID;
    err_res.bytes_total  = running_dst_r;
    err_res.bytes_linear = host_offset_r;
    err_res.last         = 1'b1;

    ent_res              = '0;
    ent_res.kind         = KIND_SCATTER;
    ent_res.dev_frag     = !is_hdr;
    ent_res.src_off      = src_off64[31:0];
    ent_res.src_address  = src_addr;
    ent_res.dst_off      = running_dst_r[31:0];
    ent_res.length       = fsize;
    ent_res.token        = is_hdr ? 32'd0 : ftok;
    ent_res.status       = ST_OK;
    ent_res.bytes_total  = dst_sum;
    ent_res.bytes_linear = host_sum;

    st_res               = '0;
    st_res.kind          = KIND_STATUS;
    st_res.status        = st;
    st_res.bytes_total   = dst_sum;
    st_res.bytes_linear  = host_sum;
    st_res.last          = 1'b1;

    r0 = err ? err_res : (entry ? ent_res : st_res);

    if (aborted_r) begin
      n_res = 2'd0;
    end else if (err) begin
      n_res = 2'd1;
    end else begin
      n_res = {1'b0, entry} + {1'b0, in_last_r};
    end
  end

  // fire only when the queue has room for every result of this record
  assign free_slots = 2'(QUEUE_DEPTH) - count_r;
  assign fire       = in_valid_r && (n_res <= free_slots);
  assign pop        = out_tvalid && out_tready;

  // message state
  always_comb begin
    host_offset_nxt = host_offset_r;
    running_dst_nxt = running_dst_r;
    saw_record_nxt  = saw_record_r;
    aborted_nxt     = aborted_r;
    saw_linear_nxt  = saw_linear_r;
    clr             = 1'b0;
    if (fire) begin
      if (aborted_r || err) begin
        clr         = in_last_r;
        aborted_nxt = !in_last_r;
      end else if (in_last_r) begin
        clr = 1'b1;
      end else begin
        host_offset_nxt = host_sum;
        running_dst_nxt = dst_sum;
        saw_record_nxt  = saw_record_r || is_rec;
        saw_linear_nxt  = saw_linear_r || (entry && is_hdr);
      end
      if (clr) begin
        host_offset_nxt = '0;
        running_dst_nxt = '0;
        saw_record_nxt  = 1'b0;
        aborted_nxt     = 1'b0;
        saw_linear_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_offset_r <= '0;
      running_dst_r <= '0;
      saw_record_r  <= 1'b0;
      aborted_r     <= 1'b0;
      saw_linear_r  <= 1'b0;
    end else begin
      host_offset_r <= host_offset_nxt;
      running_dst_r <= running_dst_nxt;
      saw_record_r  <= saw_record_nxt;
      aborted_r     <= aborted_nxt;
      saw_linear_r  <= saw_linear_nxt;
    end
  end

  // two-entry result queue, head in slot 0
  always_comb begin
    q_nxt = q_r;
    base  = count_r - {1'b0, pop};
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (fire && (n_res != 2'd0)) begin
      q_nxt[base[0]] = r0;
      if (n_res == 2'd2) begin
        q_nxt[1] = st_res;
      end
    end
    count_nxt = base + (fire ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign out_tvalid = (count_r != 2'd0);
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;
  assign out_tdata  = {4'd0, q_r[0].bytes_linear, q_r[0].bytes_total, q_r[0].status,
                       q_r[0].token, q_r[0].length, q_r[0].dst_off,
                       q_r[0].src_address, q_r[0].src_off, q_r[0].dev_frag};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_pair_needs_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (n_res == 2'd2)) |-> (count_r == 2'd0))
    else $error("two results pushed into a non-empty queue");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && aborted_r) |=> (count_r <= $past(count_r)))
    else $error("result produced while dropping an aborted message");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == out_tlast))
    else $error("status and last flag disagree");

endmodule

FILE: tb/sv/tb_devmem_cmsg_scatter_parser_core.sv
module tb_devmem_cmsg_scatter_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dcsp_pkg::*;

  localparam int IDLE_LIMIT   = 400;
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASE_ITEMS  = 120;

  typedef struct {
    logic [15:0] level;
    logic [7:0]  rtype;
    logic [31:0] foff;
    logic [31:0] fsize;
    logic [31:0] ftok;
    logic        end_only;
    logic        last_rec;
  } record_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  devmem_cmsg_scatter_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5ns clk = ~clk;

  // Register copies and per-message state of the scatter predictor
  logic [63:0] cfg_bounce_base;
  logic [31:0] cfg_bounce_size;
  logic [63:0] cfg_dmabuf_base;
  logic [31:0] cfg_dmabuf_size;
  logic [63:0] msg_host_off;
  logic [63:0] msg_run_dst;
  bit          msg_saw_record;
  bit          msg_aborted;
  bit          msg_saw_linear;

  res_t pending_results[$];

  bit no_idle;
  int items_accepted;
  int useful_items;
  int results_checked;
  int entries_seen;
  int status_seen[5];
  int config_settings;
  int fail_count;
  int idle_cycles;

  function automatic void clear_message();
    msg_host_off   = '0;
    msg_run_dst    = '0;
    msg_saw_record = 1'b0;
    msg_aborted    = 1'b0;
    msg_saw_linear = 1'b0;
  endfunction

  function automatic void expect_result(res_t e);
    pending_results = {pending_results, e};
  endfunction

  function automatic res_t status_result(status_t st);
    res_t e;
    e = '0;
    e.kind         = KIND_STATUS;
    e.status       = st;
    e.bytes_total  = msg_run_dst;
    e.bytes_linear = msg_host_off;
    e.last         = 1'b1;
    return e;
  endfunction

  function automatic void reject_fragment(logic last_rec);
    expect_result(status_result(ST_INVALID));
    if (last_rec) clear_message();
    else msg_aborted = 1'b1;
  endfunction

  function automatic void predict_results(record_t r);
    logic [31:0] sum;
    res_t        e;
    if (msg_aborted) begin
      // drop everything up to the end of the broken message
      if (r.last_rec) clear_message();
      return;
    end
    if (!r.end_only && r.level == LEVEL_SOCKET &&
        (r.rtype == TYPE_HEADER || r.rtype == TYPE_OFFSET || r.rtype == TYPE_DMABUF)) begin
      msg_saw_record = 1'b1;
      e = '0;
      e.kind = KIND_SCATTER;
      if (r.rtype == TYPE_HEADER) begin
        if (r.fsize != 0) begin
          sum = msg_host_off[31:0] + r.fsize;
          if (cfg_bounce_base == 0 || cfg_bounce_size == 0 || sum > cfg_bounce_size) begin
            reject_fragment(r.last_rec);
            return;
          end
          e.src_off     = msg_host_off[31:0];
          e.src_address = cfg_bounce_base + msg_host_off;
          e.dst_off     = msg_run_dst[31:0];
          e.length      = r.fsize;
          msg_host_off  = msg_host_off + {32'd0, r.fsize};
          msg_run_dst   = msg_run_dst + {32'd0, r.fsize};
          msg_saw_linear = 1'b1;
          e.bytes_total  = msg_run_dst;
          e.bytes_linear = msg_host_off;
          expect_result(e);
        end
      end else begin
        sum = r.foff + r.fsize;
        if (cfg_dmabuf_base != 0 && cfg_dmabuf_size != 0 && sum > cfg_dmabuf_size) begin
          reject_fragment(r.last_rec);
          return;
        end
        e.dev_frag    = 1'b1;
        e.src_off     = r.foff;
        e.src_address = cfg_dmabuf_base + {32'd0, r.foff};
        e.dst_off     = msg_run_dst[31:0];
        e.length      = r.fsize;
        e.token       = r.ftok;
        msg_run_dst   = msg_run_dst + {32'd0, r.fsize};
        e.bytes_total  = msg_run_dst;
        e.bytes_linear = msg_host_off;
        expect_result(e);
      end
    end
    if (r.last_rec) begin
      if (!msg_saw_record) expect_result(status_result(ST_NO_RECORDS));
      else if (msg_run_dst == 0) expect_result(status_result(ST_NO_DATA));
      else if (msg_saw_linear && cfg_bounce_base == 0)
        expect_result(status_result(ST_NO_BOUNCE));
      else expect_result(status_result(ST_OK));
      clear_message();
    end
  endfunction

  function automatic bit field_differs(string name, logic [63:0] e, logic [63:0] a, bit show);
    if (e !== a && show) $display("  %s: expected %h, got %h", name, e, a);
    return e !== a;
  endfunction

  // Result checker
  always @(posedge clk) begin : result_check
    res_t act;
    res_t exp;
    bit   show;
    bit   bad;
    if (rst_n && out_tvalid && out_tready) begin
      act.kind         = kind_t'(out_tuser);
      act.dev_frag     = out_tdata[0];
      act.src_off      = out_tdata[32:1];
      act.src_address  = out_tdata[96:33];
      act.dst_off      = out_tdata[128:97];
      act.length       = out_tdata[160:129];
      act.token        = out_tdata[192:161];
      act.status       = status_t'(out_tdata[195:193]);
      act.bytes_total  = out_tdata[259:196];
      act.bytes_linear = out_tdata[323:260];
      act.last         = out_tlast;
      show = fail_count < 10;
      if (pending_results.size() == 0) begin
        if (show) $display("result %0d arrived with nothing expected (kind %0d status %0d)",
                           results_checked, act.kind, act.status);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (exp.kind == KIND_STATUS) status_seen[exp.status]++;
        else entries_seen++;
        if (show && exp !== act) $display("mismatch on result %0d:", results_checked);
        bad = field_differs("kind", 64'(exp.kind), 64'(act.kind), show)
            | field_differs("dev_frag", 64'(exp.dev_frag), 64'(act.dev_frag), show)
            | field_differs("src_off", 64'(exp.src_off), 64'(act.src_off), show)
            | field_differs("src_address", exp.src_address, act.src_address, show)
            | field_differs("dst_off", 64'(exp.dst_off), 64'(act.dst_off), show)
            | field_differs("length", 64'(exp.length), 64'(act.length), show)
            | field_differs("token", 64'(exp.token), 64'(act.token), show)
            | field_differs("status", 64'(exp.status), 64'(act.status), show)
            | field_differs("bytes_total", exp.bytes_total, act.bytes_total, show)
            | field_differs("bytes_linear", exp.bytes_linear, act.bytes_linear, show)
            | field_differs("last", 64'(exp.last), 64'(act.last), show);
        if (bad) fail_count++;
      end
      results_checked++;
    end
  end

  // Watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result sink with random back-pressure
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_item(record_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {r.ftok, r.fsize, r.foff, r.rtype, r.level};
    in_tuser  = r.end_only;
    in_tlast  = r.last_rec;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_results(r);
    items_accepted++;
    if (r.last_rec || (!r.end_only && r.level == LEVEL_SOCKET &&
        (r.rtype == TYPE_HEADER || r.rtype == TYPE_OFFSET || r.rtype == TYPE_DMABUF)))
      useful_items++;
    @(negedge clk);
  endtask

  task automatic send_rec(logic [15:0] level, logic [7:0] rtype, logic [31:0] foff,
                          logic [31:0] fsize, logic [31:0] ftok, logic end_only,
                          logic last_rec);
    record_t r;
    r.level    = level;
    r.rtype    = rtype;
    r.foff     = foff;
    r.fsize    = fsize;
    r.ftok     = ftok;
    r.end_only = end_only;
    r.last_rec = last_rec;
    send_item(r);
  endtask

  // Hold the input idle until every expected result is out, plus pipeline slack
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_BOUNCE_BASE: cfg_bounce_base = value;
      REG_BOUNCE_SIZE: cfg_bounce_size = value[31:0];
      REG_DMABUF_BASE: cfg_dmabuf_base = value;
      REG_DMABUF_SIZE: cfg_dmabuf_size = value[31:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [63:0] bb, logic [63:0] bs, logic [63:0] db,
                            logic [63:0] ds);
    wait_idle();
    write_reg(REG_BOUNCE_BASE, bb);
    write_reg(REG_BOUNCE_SIZE, bs);
    write_reg(REG_DMABUF_BASE, db);
    write_reg(REG_DMABUF_SIZE, ds);
    config_settings++;
  endtask

  function automatic logic [63:0] random_reg_value(bit is_size);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(1, 65536));
      3: return {$urandom, $urandom};
      default: return is_size ? 64'($urandom_range(65536, 1 << 24)) : {$urandom, $urandom};
    endcase
  endfunction

  function automatic record_t random_record(logic last_rec);
    record_t r;
    int      pick;
    r.level    = LEVEL_SOCKET;
    r.end_only = 1'b0;
    r.last_rec = last_rec;
    r.ftok     = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.rtype = TYPE_HEADER;
    else if (pick < 66) r.rtype = TYPE_OFFSET;
    else if (pick < 90) r.rtype = TYPE_DMABUF;
    else begin
      r.level = 16'($urandom);
      r.rtype = 8'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 6) r.fsize = '0;
    else if (pick < 80) r.fsize = $urandom_range(1, 1024);
    else if (pick < 94) r.fsize = $urandom_range(1, 1 << 20);
    else r.fsize = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.foff = $urandom_range(0, 4096);
    else if (pick < 75 && cfg_dmabuf_size != 0) r.foff = $urandom_range(0, cfg_dmabuf_size);
    else r.foff = $urandom;
    if ($urandom_range(0, 19) == 0) r.end_only = 1'b1;
    return r;
  endfunction

  // One message: a few records, closed either by the last record or by an end marker
  task automatic send_random_message();
    int      n;
    bit      end_marker;
    record_t r;
    n = $urandom_range(0, 6);
    end_marker = (n == 0) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n; i++) begin
      r = random_record(!end_marker && i == n - 1);
      send_item(r);
    end
    if (end_marker) begin
      r = random_record(1'b1);
      r.end_only = 1'b1;
      send_item(r);
    end
  endtask

  task automatic test_directed_messages();
    set_config(64'h0000_1000_0000_0000, 64'h1000, 64'h0000_2000_0000_0000, 64'h0010_0000);
    // message of nothing but the end marker
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, '0, '0, 1'b1, 1'b1);
    // wrong level, then end marker
    send_rec(16'hFFFF, TYPE_HEADER, '1, '1, '1, 1'b0, 1'b0);
    send_rec('0, '0, '0, '0, '0, 1'b1, 1'b1);
    // unknown type ending the message
    send_rec(LEVEL_SOCKET, 8'hFF, '1, '1, '1, 1'b0, 1'b1);
    // empty linear fragment is skipped but counts as a record
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, '0, '1, 1'b0, 1'b1);
    // empty devmem fragment still yields an entry
    send_rec(LEVEL_SOCKET, TYPE_OFFSET, 32'h40, '0, 32'h1234_5678, 1'b0, 1'b1);
    // good message; the devmem bound sum wraps to zero
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '1, 32'h100, '1, 1'b0, 1'b0);
    send_rec(LEVEL_SOCKET, TYPE_DMABUF, '1, 32'h1, '1, 1'b0, 1'b0);
    send_rec(LEVEL_SOCKET, TYPE_OFFSET, '0, 32'h800, '0, 1'b0, 1'b0);
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, '0, '0, 1'b1, 1'b0);
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, '0, '0, 1'b1, 1'b1);
    // oversized linear fragment aborts; the rest of the message is dropped
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, 32'h1001, '0, 1'b0, 1'b0);
    send_rec(LEVEL_SOCKET, TYPE_OFFSET, '0, 32'h10, 32'hAAAA_5555, 1'b0, 1'b0);
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, 32'h10, '0, 1'b0, 1'b1);
    // devmem fragment past the dmabuf end, on the last record
    send_rec(LEVEL_SOCKET, TYPE_OFFSET, 32'h000F_FFFF, 32'h2, 32'h5555_AAAA, 1'b0, 1'b1);
    // linear fragments filling the bounce buffer exactly, then one byte too many
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, 32'h800, '0, 1'b0, 1'b0);
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, 32'h800, '0, 1'b0, 1'b0);
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, 32'h1, '0, 1'b0, 1'b1);
  endtask

  task automatic test_missing_bounce();
    set_config(64'h0000_1000_0000_0000, 64'h1000, 64'h0000_2000_0000_0000, 64'h0010_0000);
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, 32'h10, '0, 1'b0, 1'b0);
    // bounce buffer removed while the message is open
    set_config('0, 64'h1000, 64'h0000_2000_0000_0000, 64'h0010_0000);
    send_rec(LEVEL_SOCKET, TYPE_HEADER, '0, '0, '0, 1'b1, 1'b1);
  endtask

  task automatic test_config_extremes();
    set_config('0, '0, '0, '0);
    repeat (10) send_random_message();
    set_config('1, '1, '1, '1);
    repeat (10) send_random_message();
    set_config('1, '1, 64'h1, '0);
    repeat (10) send_random_message();
    set_config(64'h1, 64'h1, '0, '1);
    repeat (10) send_random_message();
  endtask

  task automatic test_random_traffic();
    int base;
    int phase_start;
    int phase;
    base  = useful_items;
    phase = 0;
    while (useful_items - base < RANDOM_ITEMS) begin
      // leave a message open across some register changes
      if (phase > 0 && $urandom_range(0, 1) == 1) begin
        send_item(random_record(1'b0));
        send_item(random_record(1'b0));
      end
      set_config(random_reg_value(1'b0), random_reg_value(1'b1),
                 random_reg_value(1'b0), random_reg_value(1'b1));
      no_idle = (phase % 4 == 3);
      phase_start = useful_items;
      while (useful_items - phase_start < PHASE_ITEMS && useful_items - base < RANDOM_ITEMS)
        send_random_message();
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr  = REG_BOUNCE_BASE;
    cfg_wdata = '0;
    no_idle   = 1'b0;
    cfg_bounce_base = '0;
    cfg_bounce_size = '0;
    cfg_dmabuf_base = '0;
    cfg_dmabuf_size = '0;
    clear_message();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_messages();
    test_missing_bounce();
    test_config_extremes();
    test_random_traffic();

    wait_idle();
    repeat (10) @(negedge clk);
    $display("%0d records in (%0d counted) over %0d register settings; %0d results checked",
             items_accepted, useful_items, config_settings, results_checked);
    $display("%0d scatter entries; statuses ok/invalid/no-records/no-data/no-bounce: %0d/%0d/%0d/%0d/%0d",
             entries_seen, status_seen[ST_OK], status_seen[ST_INVALID],
             status_seen[ST_NO_RECORDS], status_seen[ST_NO_DATA], status_seen[ST_NO_BOUNCE]);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures, %0d results still expected", fail_count, pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
